// File: rtl/core/sdot_pkg.sv
package sdot_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ID_W   = 16;
	localparam int LYR_W  = 8;
	localparam int Y_W    = 16;
	localparam int RPOS_W = 6;
	localparam int POS_W  = 6;
	localparam int ECNT_W = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LAYER  = 2'd1,
		OP_YMOVE  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [LYR_W-1:0] layer;
		logic [Y_W-1:0]   y;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INS_GO,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_FND_RD,
		ST_FND_CMP,
		ST_RM_CHK,
		ST_RM_RD,
		ST_RM_WR,
		ST_DN_CHK,
		ST_DN_RD,
		ST_DN_CMP,
		ST_UP_CHK,
		ST_UP_RD,
		ST_UP_CMP,
		ST_MV_WR,
		ST_RD_RD,
		ST_RD_CMP,
		ST_FIN
	} state_t;

endpackage

// File: rtl/core/sorted_draw_order_table.sv
// channel | handshake                  | payload
// in      | in_valid / in_stall        | op, entity_id, new_layer, new_y, read_pos
// out     | out_valid / out_stall      | ok, position, entity_out, entry_count
//
// One beat at a time; a small sequencer walks a table with one read and one write port.
// Find and insert step through a read and a compare state per entry; remove steps through
// check, read and write states, and the y walk through check, read and compare states. Layer
// change (find + remove + insert) and y change (find + neighbor walk) run these walks in turn.
// Reset clears the count, the sequencer state and out_valid; table contents are undefined until written.
// in_stall is high while an item is in work; one result waiting on out_stall does not block.
module sorted_draw_order_table
	import sdot_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               op,
	input  logic [ID_W-1:0]          entity_id,
	input  logic [LYR_W-1:0]         new_layer,
	input  logic signed [Y_W-1:0]    new_y,
	input  logic [RPOS_W-1:0]        read_pos,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic [POS_W-1:0]         position,
	output logic [ID_W-1:0]          entity_out,
	output logic [ECNT_W-1:0]        entry_count
);

	state_t                 state_q, state_d;
	op_t                    op_q;
	logic [ID_W-1:0]        id_q;
	logic [LYR_W-1:0]       layer_q;
	logic signed [Y_W-1:0]  y_q;
	logic [RPOS_W-1:0]      rpos_q;
	logic [CNT_W-1:0]       idx_q, idx_d;
	logic [CNT_W-1:0]       held_q, held_d;
	logic                   res_ok_q, res_ok_d;
	logic [CNT_W-1:0]       res_pos_q, res_pos_d;
	logic [ID_W-1:0]        res_ent_q, res_ent_d;

	logic                   out_valid_q;
	logic                   out_ok_q;
	logic [POS_W-1:0]       out_pos_q;
	logic [ID_W-1:0]        out_ent_q;
	logic [ECNT_W-1:0]      out_cnt_q;

	entry_t                 mem_q [DEPTH];
	entry_t                 rdata_q;
	logic [IDX_W-1:0]       raddr;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	entry_t                 wdata;

	logic                   accept;
	logic                   out_load;
	logic                   key_gt;
	logic                   same_layer;
	entry_t                 new_entry;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign same_layer = (rdata_q.layer == layer_q);
	assign key_gt     = (layer_q > rdata_q.layer) ||
		(same_layer && ($signed(y_q) > $signed(rdata_q.y)));
	assign new_entry  = '{id: id_q, layer: layer_q, y: y_q};

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		held_d    = held_q;
		res_ok_d  = res_ok_q;
		res_pos_d = res_pos_q;
		res_ent_d = res_ent_q;
		raddr     = idx_q[IDX_W-1:0];
		we        = 1'b0;
		waddr     = idx_q[IDX_W-1:0];
		wdata     = rdata_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_ok_d  = 1'b0;
					res_pos_d = '0;
					res_ent_d = '0;
					idx_d     = '0;
					unique case (op_t'(op))
						OP_INSERT: begin
							state_d = (held_q == CNT_W'(DEPTH)) ? ST_FIN : ST_INS_GO;
						end
						OP_LAYER, OP_YMOVE: begin
							state_d = (held_q == '0) ? ST_FIN : ST_FND_RD;
						end
						OP_READ: begin
							state_d = (CNT_W'(read_pos) < held_q) ? ST_RD_RD : ST_FIN;
						end
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_INS_GO: begin
				idx_d   = held_q;
				state_d = (held_q == '0) ? ST_INS_WR : ST_INS_RD;
			end
			ST_INS_RD: begin
				raddr   = IDX_W'(idx_q - CNT_W'(1));
				state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (key_gt) begin
					state_d = ST_INS_WR;
				end else begin
					we      = 1'b1;
					idx_d   = idx_q - CNT_W'(1);
					state_d = (idx_q == CNT_W'(1)) ? ST_INS_WR : ST_INS_RD;
				end
			end
			ST_INS_WR: begin
				we        = 1'b1;
				wdata     = new_entry;
				held_d    = held_q + CNT_W'(1);
				res_ok_d  = 1'b1;
				res_pos_d = idx_q;
				state_d   = ST_FIN;
			end
			ST_FND_RD: begin
				state_d = ST_FND_CMP;
			end
			ST_FND_CMP: begin
				if (rdata_q.id == id_q) begin
					state_d = (op_q == OP_LAYER) ? ST_RM_CHK : ST_DN_CHK;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = (idx_q + CNT_W'(1) == held_q) ? ST_FIN : ST_FND_RD;
				end
			end
			ST_RM_CHK: begin
				if (idx_q + CNT_W'(1) < held_q) begin
					state_d = ST_RM_RD;
				end else begin
					held_d  = held_q - CNT_W'(1);
					state_d = ST_INS_GO;
				end
			end
			ST_RM_RD: begin
				raddr   = IDX_W'(idx_q + CNT_W'(1));
				state_d = ST_RM_WR;
			end
			ST_RM_WR: begin
				we      = 1'b1;
				idx_d   = idx_q + CNT_W'(1);
				state_d = ST_RM_CHK;
			end
			ST_DN_CHK: begin
				state_d = (idx_q + CNT_W'(1) < held_q) ? ST_DN_RD : ST_UP_CHK;
			end
			ST_DN_RD: begin
				raddr   = IDX_W'(idx_q + CNT_W'(1));
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				if (same_layer && ($signed(y_q) > $signed(rdata_q.y))) begin
					we      = 1'b1;
					idx_d   = idx_q + CNT_W'(1);
					state_d = ST_DN_CHK;
				end else begin
					state_d = ST_UP_CHK;
				end
			end
			ST_UP_CHK: begin
				state_d = (idx_q != '0) ? ST_UP_RD : ST_MV_WR;
			end
			ST_UP_RD: begin
				raddr   = IDX_W'(idx_q - CNT_W'(1));
				state_d = ST_UP_CMP;
			end
			ST_UP_CMP: begin
				if (same_layer && ($signed(y_q) < $signed(rdata_q.y))) begin
					we      = 1'b1;
					idx_d   = idx_q - CNT_W'(1);
					state_d = ST_UP_CHK;
				end else begin
					state_d = ST_MV_WR;
				end
			end
			ST_MV_WR: begin
				we        = 1'b1;
				wdata     = new_entry;
				res_ok_d  = 1'b1;
				res_pos_d = idx_q;
				state_d   = ST_FIN;
			end
			ST_RD_RD: begin
				raddr   = IDX_W'(rpos_q);
				state_d = ST_RD_CMP;
			end
			ST_RD_CMP: begin
				res_ok_d  = 1'b1;
				res_pos_d = CNT_W'(rpos_q);
				res_ent_d = rdata_q.id;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(op);
			id_q    <= entity_id;
			layer_q <= new_layer;
			y_q     <= new_y;
			rpos_q  <= read_pos;
		end
		idx_q     <= idx_d;
		res_ok_q  <= res_ok_d;
		res_pos_q <= res_pos_d;
		res_ent_q <= res_ent_d;
		if (out_load) begin
			out_ok_q  <= res_ok_q;
			out_pos_q <= POS_W'(res_pos_q);
			out_ent_q <= res_ent_q;
			out_cnt_q <= ECNT_W'(held_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_ok_q;
	assign position    = out_pos_q;
	assign entity_out  = out_ent_q;
	assign entry_count = out_cnt_q;

endmodule
